>>> rtl/nmcs_pkg.sv
// Shared types, codes and microcode layout of the near-memory command sequencer.
`timescale 1ns / 1ps
package nmcs_pkg;

  localparam int ADDR_W = 48;
  localparam int LEN_W  = 6;

  localparam int ALIGN_BYTES_DEF = 64;
  localparam int CHANNELS_DEF    = 4;
  localparam int MAX_RUN_DEF     = 63;
  localparam int MAX_LEVELS_DEF  = 3;

  typedef enum logic [1:0] {
    K_READ  = 2'd0,
    K_WRITE = 2'd1,
    K_DONE  = 2'd2,
    K_ERROR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_FILL = 2'd0,
    OP_COPY = 2'd1,
    OP_WALK = 2'd2,
    OP_BAD  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_KIND  = 3'd1,
    ERR_IDLE  = 3'd2,
    ERR_UNEXP = 3'd3,
    ERR_BUSY  = 3'd4
  } err_t;

  // Address source for an emitted result
  typedef enum logic [2:0] {
    ASEL_RUN  = 3'd0,
    ASEL_BASE = 3'd1,
    ASEL_LVL  = 3'd2,
    ASEL_COPY = 3'd3,
    ASEL_SRC  = 3'd4,
    ASEL_ZERO = 3'd5
  } asel_t;

  // Microcode entry points
  typedef enum logic [3:0] {
    UPC_FILL_LOOP = 4'd0,
    UPC_FILL_DONE = 4'd1,
    UPC_COPY_LOOP = 4'd2,
    UPC_WALK_LOOP = 4'd3,
    UPC_COPY_RET  = 4'd4,
    UPC_WALK_RET  = 4'd5,
    UPC_RET_DONE  = 4'd6,
    UPC_ERR_KIND  = 4'd7,
    UPC_ERR_IDLE  = 4'd8,
    UPC_ERR_UNEXP = 4'd9,
    UPC_ERR_BUSY  = 4'd10
  } upc_t;

  // One control word
  typedef struct packed {
    logic  emit;       // step produces a result
    kind_t kind;
    asel_t asel;
    err_t  err;
    logic  loop;       // repeat until step count reaches limit
    logic  cond_ret;   // end unless the return completes the command
    logic  fin;        // program ends after this word
    upc_t  next_pc;
    logic  set_busy;   // open a copy or walk
    op_t   act;
    logic  count_ret;
    logic  go_idle;
  } ucode_t;

endpackage

>>> rtl/nmcs_ucode_rom.sv
// Control store of the near-memory command sequencer.
`timescale 1ns / 1ps
module nmcs_ucode_rom
  import nmcs_pkg::*;
(
  input  upc_t   pc,
  output ucode_t cw
);

  always_comb begin
    cw = '{emit: 1'b0, kind: K_READ, asel: ASEL_ZERO, err: ERR_NONE, loop: 1'b0,
           cond_ret: 1'b0, fin: 1'b1, next_pc: UPC_FILL_LOOP, set_busy: 1'b0,
           act: OP_FILL, count_ret: 1'b0, go_idle: 1'b0};
    case (pc)
      UPC_FILL_LOOP: begin
        cw.emit    = 1'b1;
        cw.kind    = K_WRITE;
        cw.asel    = ASEL_RUN;
        cw.loop    = 1'b1;
        cw.fin     = 1'b0;
        cw.next_pc = UPC_FILL_DONE;
      end
      UPC_FILL_DONE: begin
        cw.emit = 1'b1;
        cw.kind = K_DONE;
        cw.asel = ASEL_BASE;
      end
      UPC_COPY_LOOP: begin
        cw.emit     = 1'b1;
        cw.kind     = K_READ;
        cw.asel     = ASEL_RUN;
        cw.loop     = 1'b1;
        cw.set_busy = 1'b1;
        cw.act      = OP_COPY;
      end
      UPC_WALK_LOOP: begin
        cw.emit     = 1'b1;
        cw.kind     = K_READ;
        cw.asel     = ASEL_LVL;
        cw.loop     = 1'b1;
        cw.set_busy = 1'b1;
        cw.act      = OP_WALK;
      end
      UPC_COPY_RET: begin
        cw.emit      = 1'b1;
        cw.kind      = K_WRITE;
        cw.asel      = ASEL_COPY;
        cw.cond_ret  = 1'b1;
        cw.fin       = 1'b0;
        cw.next_pc   = UPC_RET_DONE;
        cw.count_ret = 1'b1;
      end
      UPC_WALK_RET: begin
        cw.cond_ret  = 1'b1;
        cw.fin       = 1'b0;
        cw.next_pc   = UPC_RET_DONE;
        cw.count_ret = 1'b1;
      end
      UPC_RET_DONE: begin
        cw.emit    = 1'b1;
        cw.kind    = K_DONE;
        cw.asel    = ASEL_SRC;
        cw.go_idle = 1'b1;
      end
      UPC_ERR_KIND: begin
        cw.emit = 1'b1;
        cw.kind = K_ERROR;
        cw.err  = ERR_KIND;
      end
      UPC_ERR_IDLE: begin
        cw.emit = 1'b1;
        cw.kind = K_ERROR;
        cw.err  = ERR_IDLE;
      end
      UPC_ERR_UNEXP: begin
        cw.emit    = 1'b1;
        cw.kind    = K_ERROR;
        cw.err     = ERR_UNEXP;
        cw.go_idle = 1'b1;
      end
      UPC_ERR_BUSY: begin
        cw.emit = 1'b1;
        cw.kind = K_ERROR;
        cw.err  = ERR_BUSY;
      end
      default: begin
        cw.emit = 1'b1;
        cw.kind = K_ERROR;
        cw.err  = ERR_KIND;
      end
    endcase
  end

endmodule

>>> rtl/near_memory_command_sequencer.sv
// Top level of the near-memory command sequencer: dispatch, microcode datapath, output register.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    operation, op_kind, addresses, length, levels
//   out      output     out_valid / out_stall  kind, req_address, error_code, last
//
// An item is taken, then the microcode emits one result per step:
// fill length+1 steps, copy length steps (one if zero), walk 1..3 steps, a return one or
// two steps, an error one step. A walk return's counting step emits nothing, so only a
// walk return that completes the command emits a result, its done.
// Reset (rst, synchronous) clears the sequencer, the output register and the engine state.
// A stalled output freezes an emitting step in progress; in_stall is high while a program
// runs, and the next item may enter while the final result still waits in the output register.
`timescale 1ns / 1ps
module near_memory_command_sequencer
  import nmcs_pkg::*;
#(
  parameter int ALIGN_BYTES = ALIGN_BYTES_DEF,
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int MAX_RUN     = MAX_RUN_DEF,
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF
)(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic [1:0]        op_kind,
  input  logic [ADDR_W-1:0] base_address,
  input  logic [LEN_W-1:0]  length,
  input  logic [ADDR_W-1:0] dest_address,
  input  logic [1:0]        level_count,
  input  logic [ADDR_W-1:0] level_addr0,
  input  logic [ADDR_W-1:0] level_addr1,
  input  logic [ADDR_W-1:0] level_addr2,
  input  logic [ADDR_W-1:0] return_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic [ADDR_W-1:0] req_address,
  output logic [2:0]        error_code,
  output logic              last
);

  // Page stride in bytes, wraps with the address
  localparam logic [ADDR_W-1:0] STRIDE   = ADDR_W'(ALIGN_BYTES * CHANNELS);
  localparam logic [LEN_W-1:0]  RUN_MAX  = LEN_W'(MAX_RUN);
  localparam logic [1:0]        LVL_MAX  = 2'(MAX_LEVELS);

  // Engine state carried between items
  logic              busy;
  op_t               active_kind;
  logic [ADDR_W-1:0] source_base;
  logic [ADDR_W-1:0] dest_base;
  logic [LEN_W-1:0]  expected_returns;
  logic [LEN_W-1:0]  received_returns;

  // Sequencer
  logic              run;
  upc_t              pc;
  logic [LEN_W-1:0]  cnt;
  logic [LEN_W-1:0]  lim;

  // Latched item
  logic [ADDR_W-1:0] cmd_base;
  logic [ADDR_W-1:0] cmd_dest;
  logic [ADDR_W-1:0] run_addr;
  logic [ADDR_W-1:0] lvl0, lvl1, lvl2;
  logic [ADDR_W-1:0] ret_off;

  ucode_t            cw;

  logic              accept;
  logic              step_go;
  logic              loop_done;
  logic              ret_done;
  logic              stay;
  logic              prog_end;
  logic [LEN_W-1:0]  len_sat;
  logic [1:0]        lvl_sat;
  logic [LEN_W-1:0]  lim_next;
  upc_t              pc_start;
  logic [ADDR_W-1:0] lvl_sel;
  logic [ADDR_W-1:0] addr_sel;

  nmcs_ucode_rom u_rom (
    .pc (pc),
    .cw (cw)
  );

  assign in_stall = run;
  assign accept   = in_valid && !run;

  // Dispatch: choose the program and its step limit
  always_comb begin
    len_sat  = (length > RUN_MAX) ? RUN_MAX : length;
    lvl_sat  = (level_count == 2'd0) ? 2'd1 : level_count;
    if (lvl_sat > LVL_MAX) begin
      lvl_sat = LVL_MAX;
    end
    lim_next = len_sat;
    pc_start = UPC_ERR_KIND;
    if (!operation) begin
      if (busy) begin
        pc_start = UPC_ERR_BUSY;
      end else begin
        case (op_t'(op_kind))
          OP_FILL: pc_start = (len_sat == '0) ? UPC_FILL_DONE : UPC_FILL_LOOP;
          OP_COPY: pc_start = (len_sat == '0) ? UPC_FILL_DONE : UPC_COPY_LOOP;
          OP_WALK: begin
            pc_start = UPC_WALK_LOOP;
            lim_next = LEN_W'(lvl_sat);
          end
          default: pc_start = UPC_ERR_KIND;
        endcase
      end
    end else if (!busy) begin
      pc_start = UPC_ERR_IDLE;
    end else begin
      case (active_kind)
        OP_COPY: pc_start = UPC_COPY_RET;
        OP_WALK: pc_start = UPC_WALK_RET;
        default: pc_start = UPC_ERR_UNEXP;
      endcase
    end
  end

  // Step control
  always_comb begin
    step_go   = run && (!cw.emit || !out_valid || !out_stall);
    loop_done = (cnt + LEN_W'(1)) == lim;
    ret_done  = (received_returns + LEN_W'(1)) == expected_returns;
    stay      = cw.loop && !loop_done;
    if (cw.cond_ret) begin
      prog_end = !ret_done;
    end else begin
      prog_end = cw.fin && !stay;
    end
  end

  // Result address
  always_comb begin
    case (cnt[1:0])
      2'd1:    lvl_sel = lvl1;
      2'd2:    lvl_sel = lvl2;
      default: lvl_sel = lvl0;
    endcase
    case (cw.asel)
      ASEL_RUN:  addr_sel = run_addr;
      ASEL_BASE: addr_sel = cmd_base;
      ASEL_LVL:  addr_sel = lvl_sel;
      ASEL_COPY: addr_sel = ret_off + dest_base;
      ASEL_SRC:  addr_sel = source_base;
      default:   addr_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run              <= 1'b0;
      pc               <= UPC_FILL_LOOP;
      out_valid        <= 1'b0;
      busy             <= 1'b0;
      active_kind      <= OP_FILL;
      source_base      <= '0;
      dest_base        <= '0;
      expected_returns <= '0;
      received_returns <= '0;
    end else begin
      // taken result leaves unless a new one replaces it in the same cycle
      if (out_valid && !out_stall && !(step_go && cw.emit)) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        run      <= 1'b1;
        pc       <= pc_start;
        cnt      <= '0;
        lim      <= lim_next;
        cmd_base <= base_address;
        cmd_dest <= dest_address;
        run_addr <= base_address;
        lvl0     <= level_addr0;
        lvl1     <= level_addr1;
        lvl2     <= level_addr2;
        // offset of the return within the copy source, wraps at 48 bits
        ret_off  <= return_address - source_base;
      end

      if (step_go) begin
        cnt <= cnt + LEN_W'(1);
        if (cw.loop) begin
          run_addr <= run_addr + STRIDE;
        end
        if (prog_end) begin
          run <= 1'b0;
        end else if (!stay) begin
          pc <= cw.next_pc;
        end

        if (cw.emit) begin
          out_valid   <= 1'b1;
          kind        <= cw.kind;
          req_address <= addr_sel;
          error_code  <= cw.err;
          last        <= prog_end;
        end

        if (cw.count_ret) begin
          received_returns <= received_returns + LEN_W'(1);
        end
        if (cw.set_busy && prog_end) begin
          busy             <= 1'b1;
          active_kind      <= cw.act;
          source_base      <= cmd_base;
          dest_base        <= (cw.act == OP_COPY) ? cmd_dest : '0;
          expected_returns <= lim;
          received_returns <= '0;
        end
        if (cw.go_idle) begin
          busy             <= 1'b0;
          active_kind      <= OP_FILL;
          expected_returns <= '0;
          received_returns <= '0;
        end
      end
    end
  end

endmodule

>>> tb/tb_near_memory_command_sequencer.sv
// Self-checking testbench for the near-memory command sequencer: stimulus, scoreboard, pacing.
`timescale 1ns / 1ps
module tb_near_memory_command_sequencer;
  import nmcs_pkg::*;

  // Operation bit of an input item
  localparam logic OPN_CMD    = 1'b0;
  localparam logic OPN_RETURN = 1'b1;

  // Byte distance between consecutive run addresses
  localparam int STRIDE       = ALIGN_BYTES_DEF * CHANNELS_DEF;
  localparam int RANDOM_ITEMS = 320;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 250;
  localparam int MAX_REPORTS  = 10;

  // One input item as the block sees it
  typedef struct {
    logic              operation;
    op_t               op_kind;
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] dest;
    logic [1:0]        levels;
    logic [ADDR_W-1:0] lvl0;
    logic [ADDR_W-1:0] lvl1;
    logic [ADDR_W-1:0] lvl2;
    logic [ADDR_W-1:0] ret;
  } mem_cmd_t;

  // One result item the block should emit
  typedef struct {
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    err_t              err;
    logic              last;
  } mem_result_t;

  // Engine model plus the queue of results still owed by the block
  class sequencer_scoreboard;
    mem_result_t       owed[$];
    int                failures;
    bit                engaged;
    op_t               active_op;
    logic [ADDR_W-1:0] src_base;
    logic [ADDR_W-1:0] dst_base;
    logic [LEN_W-1:0]  returns_due;
    logic [LEN_W-1:0]  returns_seen;

    function new();
      failures = 0;
      src_base = '0;
      dst_base = '0;
      release_engine();
    endfunction

    function void release_engine();
      engaged      = 1'b0;
      active_op    = OP_FILL;
      returns_due  = '0;
      returns_seen = '0;
    endfunction

    function void owe(kind_t k, logic [ADDR_W-1:0] a, err_t e);
      mem_result_t r;
      r.kind = k;
      r.addr = a;
      r.err  = e;
      r.last = 1'b0;
      owed.insert(owed.size(), r);
    endfunction

    // Work out the results caused by an accepted item and queue them
    function void note_item(mem_cmd_t c);
      int                first;
      int                depth;
      logic [LEN_W-1:0]  run;
      logic [ADDR_W-1:0] lv[3];
      first = owed.size();
      run   = c.len;
      lv[0] = c.lvl0;
      lv[1] = c.lvl1;
      lv[2] = c.lvl2;
      if (run > MAX_RUN_DEF) run = LEN_W'(MAX_RUN_DEF);
      if (c.operation == OPN_CMD) begin
        if (engaged) begin
          owe(K_ERROR, '0, ERR_BUSY);
        end else begin
          case (c.op_kind)
            OP_FILL: begin
              for (int i = 0; i < run; i++) owe(K_WRITE, c.base + ADDR_W'(i * STRIDE), ERR_NONE);
              owe(K_DONE, c.base, ERR_NONE);
            end
            OP_COPY: begin
              if (run == 0) begin
                owe(K_DONE, c.base, ERR_NONE);
              end else begin
                for (int i = 0; i < run; i++) owe(K_READ, c.base + ADDR_W'(i * STRIDE), ERR_NONE);
                engaged      = 1'b1;
                active_op    = OP_COPY;
                src_base     = c.base;
                dst_base     = c.dest;
                returns_due  = run;
                returns_seen = '0;
              end
            end
            OP_WALK: begin
              depth = (c.levels == 0) ? 1 : int'(c.levels);
              if (depth > MAX_LEVELS_DEF) depth = MAX_LEVELS_DEF;
              for (int i = 0; i < depth; i++) owe(K_READ, lv[i], ERR_NONE);
              engaged      = 1'b1;
              active_op    = OP_WALK;
              src_base     = c.base;
              dst_base     = '0;
              returns_due  = LEN_W'(depth);
              returns_seen = '0;
            end
            default: owe(K_ERROR, '0, ERR_KIND);
          endcase
        end
      end else if (!engaged) begin
        owe(K_ERROR, '0, ERR_IDLE);
      end else if (active_op == OP_COPY || active_op == OP_WALK) begin
        if (active_op == OP_COPY) owe(K_WRITE, (c.ret - src_base) + dst_base, ERR_NONE);
        returns_seen = returns_seen + 1'b1;
        if (returns_seen == returns_due) begin
          owe(K_DONE, src_base, ERR_NONE);
          release_engine();
        end
      end else begin
        owe(K_ERROR, '0, ERR_UNEXP);
        release_engine();
      end
      if (owed.size() > first) owed[owed.size() - 1].last = 1'b1;
    endfunction

    function void flag(string what, mem_result_t want, logic [1:0] k, logic [ADDR_W-1:0] a,
                       logic [2:0] e, logic l);
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%0t %s: exp kind=%0d addr=%h err=%0d last=%b, got kind=%0d addr=%h err=%0d last=%b",
                 $time, what, want.kind, want.addr, want.err, want.last, k, a, e, l);
    endfunction

    // Compare an accepted result with the oldest one owed
    function void check_result(logic [1:0] k, logic [ADDR_W-1:0] a, logic [2:0] e, logic l);
      mem_result_t want;
      if (owed.size() == 0) begin
        want = '{K_READ, '0, ERR_NONE, 1'b0};
        flag("result with nothing owed", want, k, a, e, l);
      end else begin
        want = owed[0];
        owed.delete(0);
        if (k !== want.kind || a !== want.addr || e !== want.err || l !== want.last)
          flag("result mismatch", want, k, a, e, l);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst            = 1'b1;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic              operation      = OPN_CMD;
  logic [1:0]        op_kind        = OP_FILL;
  logic [ADDR_W-1:0] base_address   = '0;
  logic [LEN_W-1:0]  length         = '0;
  logic [ADDR_W-1:0] dest_address   = '0;
  logic [1:0]        level_count    = 2'd1;
  logic [ADDR_W-1:0] level_addr0    = '0;
  logic [ADDR_W-1:0] level_addr1    = '0;
  logic [ADDR_W-1:0] level_addr2    = '0;
  logic [ADDR_W-1:0] return_address = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [1:0]        kind;
  logic [ADDR_W-1:0] req_address;
  logic [2:0]        error_code;
  logic              last;

  sequencer_scoreboard sb = new();
  int cycle_count = 0;
  int items_sent  = 0;
  int burst_left  = 0;

  near_memory_command_sequencer i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .op_kind        (op_kind),
    .base_address   (base_address),
    .length         (length),
    .dest_address   (dest_address),
    .level_count    (level_count),
    .level_addr0    (level_addr0),
    .level_addr1    (level_addr1),
    .level_addr2    (level_addr2),
    .return_address (return_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .req_address    (req_address),
    .error_code     (error_code),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL near_memory_command_sequencer");
    $finish;
  end

  // Zero and all-ones turn up often, so address extremes are well covered
  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ADDR_W'({$urandom, $urandom});
    endcase
  endfunction

  // Short runs mostly; the full length range now and then
  function automatic logic [LEN_W-1:0] rand_len();
    if ($urandom_range(0, 9) == 0) return LEN_W'($urandom_range(0, 63));
    return LEN_W'($urandom_range(0, 6));
  endfunction

  // Level and return fields are randomised even where the item does not use them, so their bits toggle
  function automatic mem_cmd_t make_cmd(op_t k, logic [ADDR_W-1:0] base, logic [LEN_W-1:0] len,
                                        logic [ADDR_W-1:0] dest, logic [1:0] lc);
    mem_cmd_t c;
    c.operation = OPN_CMD;
    c.op_kind   = k;
    c.base      = base;
    c.len       = len;
    c.dest      = dest;
    c.levels    = lc;
    c.lvl0      = rand_addr();
    c.lvl1      = rand_addr();
    c.lvl2      = rand_addr();
    c.ret       = rand_addr();
    return c;
  endfunction

  function automatic mem_cmd_t make_return(logic [ADDR_W-1:0] addr);
    mem_cmd_t c;
    c = make_cmd(op_t'($urandom_range(0, 3)), rand_addr(), LEN_W'($urandom_range(0, 63)),
                 rand_addr(), 2'($urandom_range(0, 3)));
    c.operation = OPN_RETURN;
    c.ret       = addr;
    return c;
  endfunction

  // Offer one item from a rising edge, hold it until taken, then maybe idle.
  // Acceptance is judged at the falling edge, where in_stall is settled.
  task automatic send_item(mem_cmd_t c);
    bit taken;
    operation      <= c.operation;
    op_kind        <= c.op_kind;
    base_address   <= c.base;
    length         <= c.len;
    dest_address   <= c.dest;
    level_count    <= c.levels;
    level_addr0    <= c.lvl0;
    level_addr1    <= c.lvl1;
    level_addr2    <= c.lvl2;
    return_address <= c.ret;
    in_valid       <= 1'b1;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sb.note_item(c);
    items_sent++;
    // Bursts of back-to-back items, sometimes separated by random gaps
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if ($urandom_range(0, 1) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // A stray command dropped into an open copy or walk; always refused as busy
  task automatic maybe_interrupt();
    if ($urandom_range(0, 9) == 0)
      send_item(make_cmd(op_t'($urandom_range(0, 3)), rand_addr(), rand_len(), rand_addr(),
                         2'($urandom_range(0, 3))));
  endtask

  // Result side: every accepted result goes to the scoreboard
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(kind, req_address, error_code, last);
  end

  // Receiver pacing: free flow, random stalls, a long hold-off once, a fixed pattern, heavy stalls
  initial begin : receiver_pacing
    int pass;
    int period;
    pass = 0;
    wait (!rst);
    forever begin
      repeat (150) begin
        @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat (150) begin
        @(posedge clk);
        out_stall <= ($urandom_range(0, 99) < 30);
      end
      // Long hold-off on the first pass only, so the block backs up into its input
      if (pass == 0) begin
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end
      period = $urandom_range(2, 5);
      for (int n = 0; n < 150; n++) begin
        @(posedge clk);
        out_stall <= (n % period) == 0;
      end
      repeat (150) begin
        @(posedge clk);
        out_stall <= ($urandom_range(0, 99) < 70);
      end
      pass++;
    end
  end

  initial begin : stimulus
    mem_cmd_t          c;
    logic [ADDR_W-1:0] src;
    logic [LEN_W-1:0]  len;
    int                depth;
    int                pick;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // empty fill: done only
    send_item(make_cmd(OP_FILL, rand_addr(), 6'd0, rand_addr(), 2'd1));
    // longest fill, start near the top so the run addresses wrap
    send_item(make_cmd(OP_FILL, 48'hFFFF_FFFF_FF00, 6'd63, '0, 2'd3));
    send_item(make_cmd(OP_FILL, '0, 6'd1, '1, 2'd0));
    // unknown kind, then a return with nothing open
    send_item(make_cmd(OP_BAD, '1, 6'd63, '1, 2'd3));
    send_item(make_return('1));
    // empty copy answers at once and leaves the engine idle
    send_item(make_cmd(OP_COPY, 48'h1234_5678_9ABC, 6'd0, '1, 2'd2));
    // two-word copy; a command while it is open is refused
    send_item(make_cmd(OP_COPY, '1, 6'd2, 48'h10, 2'd1));
    send_item(make_cmd(OP_FILL, rand_addr(), 6'd5, rand_addr(), 2'd1));
    send_item(make_return('1));
    send_item(make_return('0));           // offset wraps below the source base
    // walk depth zero is taken as one level
    c = make_cmd(OP_WALK, 48'hABCD_0000_0001, 6'd0, rand_addr(), 2'd0);
    c.lvl0 = '1;
    send_item(c);
    send_item(make_return(rand_addr()));
    // full-depth walk; intermediate returns are silent
    c = make_cmd(OP_WALK, '1, 6'd63, '1, 2'd3);
    c.lvl0 = '0;
    c.lvl2 = '1;
    send_item(c);
    send_item(make_cmd(OP_BAD, '0, 6'd0, '0, 2'd0));
    repeat (3) send_item(make_return(rand_addr()));
    send_item(make_cmd(OP_WALK, '0, 6'd1, '0, 2'd2));
    repeat (2) send_item(make_return(rand_addr()));
    // three-word copy onto the top of the address space
    send_item(make_cmd(OP_COPY, '0, 6'd3, '1, 2'd3));
    send_item(make_return('1));
    send_item(make_return('0));
    send_item(make_return(rand_addr()));
    send_item(make_return('0));           // late return after completion

    // ---- random part: mostly complete copy and walk sequences ----
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        send_item(make_cmd(OP_FILL, rand_addr(), rand_len(), rand_addr(),
                           2'($urandom_range(0, 3))));
      end else if (pick < 58) begin
        src = rand_addr();
        len = rand_len();
        send_item(make_cmd(OP_COPY, src, len, rand_addr(), 2'($urandom_range(0, 3))));
        for (int i = 0; i < len; i++) begin
          maybe_interrupt();
          // returns usually land on the requested words, sometimes anywhere
          if ($urandom_range(0, 3) == 0) send_item(make_return(rand_addr()));
          else send_item(make_return(src + ADDR_W'(i * STRIDE)));
        end
      end else if (pick < 85) begin
        c = make_cmd(OP_WALK, rand_addr(), rand_len(), rand_addr(), 2'($urandom_range(0, 3)));
        send_item(c);
        depth = (c.levels == 0) ? 1 : int'(c.levels);
        for (int i = 0; i < depth; i++) begin
          maybe_interrupt();
          send_item(make_return(rand_addr()));
        end
      end else if (pick < 92) begin
        send_item(make_cmd(OP_BAD, rand_addr(), rand_len(), rand_addr(),
                           2'($urandom_range(0, 3))));
      end else begin
        send_item(make_return(rand_addr()));
      end
    end
    in_valid <= 1'b0;

    // Drain everything owed, then watch a little longer for stray results
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.owed.size() == 0) begin
      $display("PASS near_memory_command_sequencer");
    end else begin
      $display("FAIL near_memory_command_sequencer");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/nmcs_pkg.sv
rtl/nmcs_ucode_rom.sv
rtl/near_memory_command_sequencer.sv
tb/tb_near_memory_command_sequencer.sv
